### rtl/code_point_to_utf8_encoder_core_assert.svh
// assertion helpers for the utf-8 encoder
`ifndef CODE_POINT_TO_UTF8_ENCODER_CORE_ASSERT_SVH
`define CODE_POINT_TO_UTF8_ENCODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CP2U8_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cp2u8 same-cycle check failed");

// next-cycle implication
`define CP2U8_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cp2u8 next-cycle check failed");

`else

`define CP2U8_ASSERT_NOW(label, clk, rst, ante, cons)
`define CP2U8_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/cp2u8_pkg.sv
package cp2u8_pkg;

   // field widths
   localparam int CpW      = 21;
   localparam int ByteW    = 8;
   localparam int MaxBytes = 7;
   localparam int SeqBytes = 4;
   localparam int CntW     = 3;
   localparam int HeldW    = 10;
   localparam int Q_DEPTH  = 2;

   // code point limits
   localparam logic [CpW-1:0] CP_MAX     = 21'h10FFFF;
   localparam logic [CpW-1:0] CP_SUPP    = 21'h010000;
   localparam logic [CpW-1:0] SURR_HI_LO = 21'h00D800;
   localparam logic [CpW-1:0] SURR_HI_HI = 21'h00DBFF;
   localparam logic [CpW-1:0] SURR_LO_LO = 21'h00DC00;
   localparam logic [CpW-1:0] SURR_LO_HI = 21'h00DFFF;
   localparam logic [CpW-1:0] ONE_MAX    = 21'h00007F;
   localparam logic [CpW-1:0] TWO_MAX    = 21'h0007FF;

   // lead and continuation marks
   localparam logic [ByteW-1:0] LEAD2 = 8'hC0;
   localparam logic [ByteW-1:0] LEAD3 = 8'hE0;
   localparam logic [ByteW-1:0] LEAD4 = 8'hF0;
   localparam logic [ByteW-1:0] CONT  = 8'h80;

   // one encoded sequence, first byte in the low bits
   typedef struct packed {
      logic [SeqBytes*ByteW-1:0] bytes;
      logic [CntW-1:0]           count;
   } seq_type;

   // work handed from front to back
   typedef struct packed {
      logic [MaxBytes*ByteW-1:0] bytes;
      logic [CntW-1:0]           count;
      logic                      eos;
      logic                      err;
   } job_type;

   function automatic seq_type put_one(input logic [6:0] c);
      seq_type s;
      s.bytes = {24'h000000, 1'b0, c};
      s.count = 3'd1;
      return s;
   endfunction

   function automatic seq_type put_two(input logic [10:0] c);
      seq_type s;
      s.bytes = {16'h0000, CONT | {2'b00, c[5:0]}, LEAD2 | {3'b000, c[10:6]}};
      s.count = 3'd2;
      return s;
   endfunction

   function automatic seq_type put_three(input logic [15:0] c);
      seq_type s;
      s.bytes = {8'h00, CONT | {2'b00, c[5:0]}, CONT | {2'b00, c[11:6]},
                 LEAD3 | {4'h0, c[15:12]}};
      s.count = 3'd3;
      return s;
   endfunction

   function automatic seq_type put_four(input logic [CpW-1:0] c);
      seq_type s;
      s.bytes = {CONT | {2'b00, c[5:0]}, CONT | {2'b00, c[11:6]},
                 CONT | {2'b00, c[17:12]}, LEAD4 | {5'b00000, c[20:18]}};
      s.count = 3'd4;
      return s;
   endfunction

endpackage

### rtl/cp2u8_req_if.sv
interface cp2u8_req_if;
   logic                       valid;
   logic                       ready;
   logic [cp2u8_pkg::CpW-1:0]  code_point;
   logic                       end_of_string;

   modport source (output valid, code_point, end_of_string, input ready);
   modport sink   (input valid, code_point, end_of_string, output ready);
endinterface

### rtl/cp2u8_rsp_if.sv
interface cp2u8_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [cp2u8_pkg::ByteW-1:0]  out_byte;
   logic                         run_last;
   logic                         string_done;
   logic                         range_error;

   modport source (output valid, out_byte, run_last, string_done, range_error,
                   input ready);
   modport sink   (input valid, out_byte, run_last, string_done, range_error,
                   output ready);
endinterface

### rtl/cp2u8_front.sv
module cp2u8_front (
   input  logic               clock,
   input  logic               reset,
   cp2u8_req_if.sink          req_bus,
   input  logic               push_ok,
   output logic               push,
   output cp2u8_pkg::job_type push_job
);
   import cp2u8_pkg::*;

   logic [HeldW-1:0] held_ff, held_in;
   logic             held_valid_ff, held_valid_in;
   logic             dropping_ff, dropping_in;
   logic             accept;
   logic [CpW-1:0]   cp;
   logic             eos;
   logic             is_high, is_low;
   logic [CpW-1:0]   joined;
   seq_type          flush_seq, main_seq;
   logic             flush, emit_seq;
   job_type          job;

   assign req_bus.ready = push_ok;
   assign accept        = req_bus.valid & push_ok;
   assign cp            = req_bus.code_point;
   assign eos           = req_bus.end_of_string;

   // surrogate classification
   assign is_high   = (cp >= SURR_HI_LO) && (cp <= SURR_HI_HI);
   assign is_low    = (cp >= SURR_LO_LO) && (cp <= SURR_LO_HI);
   assign joined    = CP_SUPP + CpW'({held_ff, cp[HeldW-1:0]});
   assign flush_seq = put_three(SURR_HI_LO[15:0] | {6'b000000, held_ff});

   // classify the word and build the job
   always_comb begin
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      dropping_in   = dropping_ff;
      main_seq      = '0;
      flush         = 1'b0;
      emit_seq      = 1'b0;
      job           = '0;
      job.eos       = eos;
      priority if (dropping_ff) begin
         if (eos) begin
            dropping_in = 1'b0;
         end
      end else if (cp > CP_MAX) begin
         // the error word always closes the string
         held_valid_in = 1'b0;
         held_in       = '0;
         job.count     = 3'd1;
         job.err       = 1'b1;
         job.eos       = 1'b1;
         dropping_in   = !eos;
      end else if (held_valid_ff && is_low) begin
         main_seq      = put_four(joined);
         emit_seq      = 1'b1;
         held_valid_in = 1'b0;
         held_in       = '0;
      end else begin
         flush         = held_valid_ff;
         emit_seq      = 1'b1;
         held_valid_in = 1'b0;
         held_in       = '0;
         priority if (cp >= CP_SUPP) begin
            main_seq = put_four(cp);
         end else if (is_high && !eos) begin
            held_in       = cp[HeldW-1:0];
            held_valid_in = 1'b1;
         end else if (cp <= ONE_MAX) begin
            main_seq = put_one(cp[6:0]);
         end else if (cp <= TWO_MAX) begin
            main_seq = put_two(cp[10:0]);
         end else begin
            main_seq = put_three(cp[15:0]);
         end
      end
      if (emit_seq) begin
         if (flush) begin
            job.bytes = {main_seq.bytes, flush_seq.bytes[23:0]};
            job.count = main_seq.count + 3'd3;
         end else begin
            job.bytes = {24'h000000, main_seq.bytes};
            job.count = main_seq.count;
         end
      end
   end

   assign push     = accept && (job.count != '0);
   assign push_job = job;

   // surrogate and drop state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         dropping_ff   <= 1'b0;
      end else if (accept) begin
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         dropping_ff   <= dropping_in;
      end
   end

endmodule

### rtl/cp2u8_queue.sv
module cp2u8_queue #(
   parameter int Depth = cp2u8_pkg::Q_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cp2u8_pkg::job_type push_job,
   output logic               push_ok,
   input  logic               pop,
   output logic               head_valid,
   output cp2u8_pkg::job_type head_job
);
   import cp2u8_pkg::*;

   localparam int PtrW = $clog2(Depth);
   localparam int CntQW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0]  LastPtr = PtrW'(Depth - 1);
   localparam logic [CntQW-1:0] FullCnt = CntQW'(Depth);

   job_type          slot_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CntQW-1:0] count_ff;

   assign push_ok    = count_ff != FullCnt;
   assign head_valid = count_ff != '0;
   assign head_job   = slot_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### rtl/cp2u8_back.sv
module cp2u8_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  cp2u8_pkg::job_type head_job,
   output logic               pop,
   cp2u8_rsp_if.source        rsp_bus
);
   import cp2u8_pkg::*;

   job_type          work_ff, work_in;
   logic             work_valid_ff, work_valid_in;
   logic [CntW-1:0]  idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   logic [ByteW-1:0] byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             done_ff, done_in;
   logic             err_ff, err_in;
   logic             out_free, emit, work_last;

   assign out_free  = !out_valid_ff || rsp_bus.ready;
   assign emit      = work_valid_ff && out_free;
   assign work_last = idx_ff == (work_ff.count - 1'b1);
   assign pop       = head_valid && (!work_valid_ff || (emit && work_last));

   // job sequencing
   always_comb begin
      work_in       = work_ff;
      work_valid_in = work_valid_ff;
      idx_in        = idx_ff;
      if (pop) begin
         work_in       = head_job;
         work_valid_in = 1'b1;
         idx_in        = '0;
      end else if (emit && work_last) begin
         work_valid_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      done_in      = done_ff;
      err_in       = err_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         byte_in      = work_ff.bytes[idx_ff*ByteW +: ByteW];
         last_in      = work_last;
         done_in      = work_last && work_ff.eos;
         err_in       = work_ff.err;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      idx_ff  <= idx_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      done_ff <= done_in;
      err_ff  <= err_in;
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.out_byte    = byte_ff;
   assign rsp_bus.run_last    = last_ff;
   assign rsp_bus.string_done = done_ff;
   assign rsp_bus.range_error = err_ff;

endmodule

### rtl/code_point_to_utf8_encoder_core.sv
// UTF-8 encoder: takes one code point per request word and returns its UTF-8
// encoding one byte per response word. A bare high surrogate is held and joined
// with a following low surrogate into a 4-byte sequence, or flushed as 3 bytes
// by any other in-range word or by end of string; a code point above 0x10FFFF
// discards it and returns a single zero byte flagged range_error and
// string_done, after which words are dropped up to and including the
// end-of-string word. The front classifies a word in the cycle it is taken and
// queues up to seven bytes of work; the back sends one byte per cycle through a
// registered output while the receiver is ready. An item yields one to seven
// bytes (usually one to four), and items that produce nothing are not queued.
// When the queue and output are empty, the first byte passes through the job
// queue, the back's work register and the output register before it reaches
// the response port. Request ready drops only when the job queue is full.
`include "code_point_to_utf8_encoder_core_assert.svh"

module code_point_to_utf8_encoder_core #(
   parameter int QUEUE_DEPTH = cp2u8_pkg::Q_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   cp2u8_req_if.sink    req_bus,
   cp2u8_rsp_if.source  rsp_bus
);
   import cp2u8_pkg::*;

   logic    q_push, q_push_ok, q_pop, q_head_valid;
   job_type q_push_job, q_head_job;

   // classify and track surrogate state
   cp2u8_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .push_ok  (q_push_ok),
      .push     (q_push),
      .push_job (q_push_job)
   );

   // job queue between front and back
   cp2u8_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_push_job),
      .push_ok    (q_push_ok),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_job   (q_head_job)
   );

   // byte serializer
   cp2u8_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_job   (q_head_job),
      .pop        (q_pop),
      .rsp_bus    (rsp_bus)
   );

   // checks
   `CP2U8_ASSERT_NOW(a_err_word, clock, reset, rsp_bus.valid && rsp_bus.range_error, rsp_bus.run_last && rsp_bus.string_done && (rsp_bus.out_byte == '0))
   `CP2U8_ASSERT_NOW(a_done_last, clock, reset, rsp_bus.valid && rsp_bus.string_done, rsp_bus.run_last)
   `CP2U8_ASSERT_NOW(a_pop_nonempty_job, clock, reset, q_pop, q_head_job.count != '0)
   `CP2U8_ASSERT_NEXT(a_no_pop_from_empty, clock, reset, !q_head_valid && !q_push, !q_pop)

endmodule

### tb/code_point_to_utf8_encoder_core_tb.sv
`timescale 1ns / 100ps

module code_point_to_utf8_encoder_core_tb;
   import cp2u8_pkg::*;

   localparam int HOLD_CYCLES    = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 16;
   localparam int TOTAL_WORDS    = 410;

   // one expected output word
   typedef struct packed {
      logic [ByteW-1:0] out_byte;
      logic             run_last;
      logic             string_done;
      logic             range_error;
   } utf8_byte_type;

   // predicts the byte stream and checks the output words against it
   class utf8_byte_predictor;
      utf8_byte_type    due_bytes[$];
      logic [HeldW-1:0] held_high;
      logic             held_valid;
      logic             dropping;
      int               words_in;
      int               words_dropped;
      int               bytes_checked;
      int               pairs_joined;
      int               flushes;
      int               range_aborts;
      int               faults;

      function new();
         held_high     = '0;
         held_valid    = 1'b0;
         dropping      = 1'b0;
         words_in      = 0;
         words_dropped = 0;
         bytes_checked = 0;
         pairs_joined  = 0;
         flushes       = 0;
         range_aborts  = 0;
         faults        = 0;
      endfunction

      function int live_words();
         return words_in - words_dropped;
      endfunction

      function void report(string msg);
         faults++;
         if (faults <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
         end
      endfunction

      function void push_byte(logic [ByteW-1:0] b);
         utf8_byte_type w;
         w.out_byte    = b;
         w.run_last    = 1'b0;
         w.string_done = 1'b0;
         w.range_error = 1'b0;
         due_bytes = {due_bytes, w};
      endfunction

      function void push_three(logic [15:0] c);
         push_byte(LEAD3 | {4'h0, c[15:12]});
         push_byte(CONT | {2'b00, c[11:6]});
         push_byte(CONT | {2'b00, c[5:0]});
      endfunction

      function void push_four(logic [CpW-1:0] c);
         push_byte(LEAD4 | {5'b00000, c[20:18]});
         push_byte(CONT | {2'b00, c[17:12]});
         push_byte(CONT | {2'b00, c[11:6]});
         push_byte(CONT | {2'b00, c[5:0]});
      endfunction

      // work out the bytes caused by one accepted code point
      function void take_code_point(logic [CpW-1:0] cp, logic eos);
         int               base;
         utf8_byte_type    w;
         logic [CpW-1:0]   joined;
         base = due_bytes.size();
         words_in++;
         // aborted string: swallow words up to the end marker
         if (dropping) begin
            words_dropped++;
            if (eos) begin
               dropping = 1'b0;
            end
            return;
         end
         // out of range aborts the string with one flagged word
         if (cp > CP_MAX) begin
            held_valid    = 1'b0;
            held_high     = '0;
            w.out_byte    = '0;
            w.run_last    = 1'b1;
            w.string_done = 1'b1;
            w.range_error = 1'b1;
            due_bytes = {due_bytes, w};
            range_aborts++;
            dropping = !eos;
            return;
         end
         if (held_valid && cp >= SURR_LO_LO && cp <= SURR_LO_HI) begin
            // join the held high half with this low half
            joined = CP_SUPP + {1'b0, held_high, 10'h000} + {11'h000, cp[9:0]};
            held_valid = 1'b0;
            held_high  = '0;
            push_four(joined);
            pairs_joined++;
         end else begin
            // anything else flushes a held high half first
            if (held_valid) begin
               push_three(SURR_HI_LO[15:0] | {6'b000000, held_high});
               held_valid = 1'b0;
               held_high  = '0;
               flushes++;
            end
            if (cp >= CP_SUPP) begin
               push_four(cp);
            end else if (cp >= SURR_HI_LO && cp <= SURR_HI_HI && !eos) begin
               held_high  = cp[HeldW-1:0];
               held_valid = 1'b1;
            end else if (cp <= ONE_MAX) begin
               push_byte({1'b0, cp[6:0]});
            end else if (cp <= TWO_MAX) begin
               push_byte(LEAD2 | {3'b000, cp[10:6]});
               push_byte(CONT | {2'b00, cp[5:0]});
            end else begin
               push_three(cp[15:0]);
            end
         end
         // flag the last byte of this word
         if (due_bytes.size() > base) begin
            w = due_bytes.pop_back();
            w.run_last    = 1'b1;
            w.string_done = eos;
            due_bytes = {due_bytes, w};
         end
      endfunction

      // compare one output word with the oldest expected one
      function void match_byte(logic [ByteW-1:0] b, logic last, logic done, logic err);
         utf8_byte_type w;
         if (due_bytes.size() == 0) begin
            report($sformatf("unexpected word byte %02h last %b done %b err %b",
                             b, last, done, err));
            return;
         end
         w = due_bytes.pop_front();
         bytes_checked++;
         if (w.out_byte !== b || w.run_last !== last || w.string_done !== done ||
             w.range_error !== err) begin
            report($sformatf({"expected byte %02h last %b done %b err %b, ",
                              "got byte %02h last %b done %b err %b"},
                             w.out_byte, w.run_last, w.string_done, w.range_error,
                             b, last, done, err));
         end
      endfunction

      function void close_out();
         if (due_bytes.size() != 0) begin
            report($sformatf("%0d expected words never arrived", due_bytes.size()));
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   cp2u8_req_if req_bus ();
   cp2u8_rsp_if rsp_bus ();

   utf8_byte_predictor sb;
   bit steady;
   bit hold_req;
   int rsp_wait;
   int hold_offs;
   int idle_cycles;

   code_point_to_utf8_encoder_core u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // monitor both channels and watch for a hang
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            sb.take_code_point(req_bus.code_point, req_bus.end_of_string);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.match_byte(rsp_bus.out_byte, rsp_bus.run_last, rsp_bus.string_done,
                          rsp_bus.range_error);
            rsp_wait = steady ? 0 : $urandom_range(0, 3);
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("watchdog: no word moved for %0d cycles", idle_cycles);
               $display("code_point_to_utf8_encoder_core_tb NOT OK");
               $finish;
            end
         end
      end
   end

   // receiver: random stalls per word, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req = 1'b0;
         rsp_wait = HOLD_CYCLES;
         hold_offs++;
      end
      if (rsp_wait > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // offer one code point and wait until it is taken
   task automatic send_word(input logic [CpW-1:0] cp, input logic eos);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.code_point    <= cp;
      req_bus.end_of_string <= eos;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // stop sending until every expected word has come back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (sb.due_bytes.size() != 0) @(negedge clock);
   endtask

   // one random string, mostly well-formed text with some broken surrogates and out-of-range words
   task automatic send_string();
      int             len;
      int             pick;
      int             i;
      logic           last;
      len = $urandom_range(1, 8);
      for (i = 0; i < len; i++) begin
         last = (i == len - 1);
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            send_word(CpW'($urandom_range(0, ONE_MAX)), last);
         end else if (pick < 45) begin
            send_word(CpW'($urandom_range(ONE_MAX + 1, TWO_MAX)), last);
         end else if (pick < 60) begin
            send_word(CpW'($urandom_range(TWO_MAX + 1, CP_SUPP - 1)), last);
         end else if (pick < 75) begin
            send_word(CpW'($urandom_range(SURR_HI_LO, SURR_HI_HI)), 1'b0);
            send_word(CpW'($urandom_range(SURR_LO_LO, SURR_LO_HI)), last);
         end else if (pick < 80) begin
            send_word(CpW'($urandom_range(SURR_HI_LO, SURR_HI_HI)), last);
         end else if (pick < 84) begin
            send_word(CpW'($urandom_range(SURR_LO_LO, SURR_LO_HI)), last);
         end else if (pick < 96) begin
            send_word(CpW'($urandom_range(CP_SUPP, CP_MAX)), last);
         end else begin
            send_word(CpW'($urandom_range(CP_MAX + 1, {CpW{1'b1}})),
                      last | 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // stimulus
   initial begin
      logic [CpW:0] directed [26];
      bit           paused;
      bit           held;
      sb = new();
      steady   = 1'b0;
      hold_req = 1'b0;
      rsp_wait = 0;
      hold_offs = 0;
      paused   = 1'b0;
      held     = 1'b0;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.code_point    = '0;
      req_bus.end_of_string = 1'b0;
      rsp_bus.ready         = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // edges of each length class, abort and drop, surrogate corner cases
      directed = '{
         {1'b0, 21'h000000}, {1'b0, 21'h00007F}, {1'b0, 21'h000080}, {1'b0, 21'h0007FF},
         {1'b0, 21'h000800}, {1'b0, 21'h00FFFF}, {1'b0, 21'h010000}, {1'b0, 21'h10FFFF},
         {1'b0, 21'h110000}, {1'b0, 21'h000041}, {1'b1, 21'h000042},
         {1'b0, 21'h00D800}, {1'b0, 21'h00DC00},
         {1'b0, 21'h00DBFF}, {1'b1, 21'h00DFFF},
         {1'b0, 21'h00D800}, {1'b0, 21'h000041},
         {1'b1, 21'h00DBFF},
         {1'b0, 21'h00D800}, {1'b1, 21'h00D801},
         {1'b1, 21'h00DC00},
         {1'b0, 21'h00D800}, {1'b1, 21'h1FFFFF},
         {1'b0, 21'h00D800}, {1'b0, 21'h010000},
         {1'b1, 21'h00E000}
      };
      foreach (directed[i]) begin
         send_word(directed[i][CpW-1:0], directed[i][CpW]);
      end
      drain_results();

      // random strings with one full pause and one long receiver hold-off
      while (sb.live_words() < TOTAL_WORDS) begin
         if (!paused && sb.live_words() > 160) begin
            paused = 1'b1;
            drain_results();
         end
         if (!held && sb.live_words() > 280) begin
            held = 1'b1;
            drain_results();
            @(posedge clock);
            hold_req = 1'b1;
            @(negedge clock);
            steady = 1'b1;
            repeat (6) send_string();
         end
         steady = ($urandom_range(0, 5) == 0);
         send_string();
      end
      steady = 1'b0;
      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      sb.close_out();

      $display("encoded %0d code points (%0d dropped after aborts) into %0d checked bytes",
               sb.words_in, sb.words_dropped, sb.bytes_checked);
      $display("%0d pairs joined, %0d held halves flushed, %0d range aborts, %0d hold-offs",
               sb.pairs_joined, sb.flushes, sb.range_aborts, hold_offs);
      if (sb.faults == 0) begin
         $display("code_point_to_utf8_encoder_core_tb OK");
      end else begin
         $display("%0d mismatches", sb.faults);
         $display("code_point_to_utf8_encoder_core_tb NOT OK");
      end
      $finish;
   end

endmodule
